### sv/vso_pkg.sv
// Shared constants for the variable-slope oscillator.
`default_nettype none
package vso_pkg;

  localparam int unsigned FREQ_W      = 32;
  localparam int unsigned WIDTH_W     = 16;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned SYNC_W      = 33;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned INV_RATE_W  = 40;

  // Shared multiplier operand widths: 33 bits covers one-minus-phase.
  localparam int unsigned MUL_A_W     = 33;
  localparam int unsigned MUL_B_W     = 32;

  localparam logic [INV_RATE_W-1:0] INV_RATE_RESET = 40'd5864062015;

  localparam int signed   WIDTH_ONE   = 16384;
  localparam int unsigned FULL_SCALE  = 32768;
  localparam logic [40:0] HALF_STEP   = 41'h0_8000_0000;

endpackage : vso_pkg
`default_nettype wire

### sv/variable_slope_oscillator.sv
// Top level of the variable-slope triangle/saw oscillator.
//
// One input transaction (frequency, slope width, phase offset, sync) gives one
// output transaction (sample, Q1.15). Both channels use valid/ready. The
// single config register inverse_rate is written via cfg_wr_en / cfg_wr_data
// with no wait; the user must write it only while idle, which is not checked.
//
// Sequencing: a sequencer drives one registered 33x32 multiplier and one
// 48-bit subtract/compare unit. The phase step runs through S_MLO, S_MHI and
// S_STEP (two partial products against the 40-bit rate register, then clip).
// Full saws then go straight to S_FIN. Other widths take three products, a
// divider load and a 17-step restoring division before S_FIN. in_ready is
// high only while the sequencer is idle, so one item is in flight and the
// next item is not taken before the previous one has left S_FIN.
//
// The output register parts the two sides: a finished sample may wait on
// out_ready while the next transaction is already accepted; the sequencer
// only stalls in its final state if the previous sample has not been taken.
// Reset (synchronous, active low) clears phase and previous offset to zero,
// loads inverse_rate with its 48 kHz default and drops out_valid.
`default_nettype none
module variable_slope_oscillator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [vso_pkg::INV_RATE_W-1:0]      cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [vso_pkg::FREQ_W-1:0]   in_frequency,
  input  wire logic signed [vso_pkg::WIDTH_W-1:0]  in_slope_width,
  input  wire logic [vso_pkg::PHASE_W-1:0]         in_phase_offset,
  input  wire logic [vso_pkg::SYNC_W-1:0]          in_sync,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [vso_pkg::SAMPLE_W-1:0]      out_sample
);
  import vso_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MLO,   // magnitude x low word of inverse_rate
    S_MHI,   // magnitude x high byte, fold in low product
    S_STEP,  // clip step, advance phase
    S_MINC,  // P * W
    S_MDEC,  // (1 - P) * V
    S_MD,    // W * V, take minimum
    S_DSET,  // load divider
    S_DIV,   // one quotient bit per cycle
    S_FIN    // saturate and present result
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic                  out_valid_r, out_valid_nxt;
  logic [PHASE_W-1:0]    phase_acc_r, phase_acc_nxt;
  logic [PHASE_W-1:0]    prev_off_r, prev_off_nxt;
  logic [INV_RATE_W-1:0] inv_rate_r, inv_rate_nxt;
  logic [4:0]            cnt_r, cnt_nxt;

  // Working registers
  logic [FREQ_W-1:0]     mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [PHASE_W-1:0]    p_r, p_nxt;
  logic [14:0]           w_r, w_nxt;
  logic [14:0]           v_r, v_nxt;
  logic                  saw_fall_r, saw_fall_nxt;
  logic                  saw_rise_r, saw_rise_nxt;
  logic [32:0]           acc_r, acc_nxt;
  logic [46:0]           inc_r, inc_nxt;
  logic [46:0]           m_r, m_nxt;
  logic [47:0]           rem_r, rem_nxt;
  logic [47:0]           dvs_r, dvs_nxt;
  logic [16:0]           quo_r, quo_nxt;
  logic [SAMPLE_W-1:0]   sample_r, sample_nxt;

  // Shared multiplier
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] prod;

  vso_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Phase at acceptance: sync jump, reset, or offset change
  logic [PHASE_W-1:0] p_in;
  always_comb begin
    if (in_sync != '0 && !in_sync[SYNC_W-1]) begin
      p_in = in_sync[PHASE_W-1:0];
    end else if (in_sync == {1'b1, {PHASE_W{1'b0}}}) begin
      p_in = '0;
    end else begin
      p_in = phase_acc_r + (in_phase_offset - prev_off_r);
    end
  end

  // Width clip and split into W and V = 1 - W
  logic signed [WIDTH_W:0] w_ext;
  assign w_ext = (WIDTH_W+1)'(in_slope_width) + (WIDTH_W+1)'(WIDTH_ONE);

  // Step arithmetic
  logic [40:0]        q_sum;
  logic [PHASE_W-1:0] q_clip;
  logic [PHASE_W-1:0] step;
  assign q_sum  = prod[40:0] + {8'd0, acc_r};
  assign q_clip = (q_sum > HALF_STEP) ? HALF_STEP[PHASE_W-1:0] : q_sum[PHASE_W-1:0];
  assign step   = neg_r ? (PHASE_W'(0) - q_clip) : q_clip;

  // Divider trial subtract
  logic [47:0] rem_sub;
  logic        rem_ge;
  assign rem_ge  = (rem_r >= dvs_r);
  assign rem_sub = rem_r - dvs_r;

  // Final shaping
  logic [32:0]  p_round;
  logic [16:0]  q_saw;
  logic [17:0]  res;
  assign p_round = {1'b0, p_r} + 33'h0_0000_8000;
  assign q_saw   = p_round[32:16];

  always_comb begin
    if (saw_fall_r) begin
      res = 18'(FULL_SCALE) - {1'b0, q_saw};
    end else if (saw_rise_r) begin
      res = {1'b0, q_saw} - 18'(FULL_SCALE);
    end else begin
      res = 18'(FULL_SCALE) - {1'b0, quo_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    phase_acc_nxt = phase_acc_r;
    prev_off_nxt  = prev_off_r;
    inv_rate_nxt  = inv_rate_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    p_nxt         = p_r;
    w_nxt         = w_r;
    v_nxt         = v_r;
    saw_fall_nxt  = saw_fall_r;
    saw_rise_nxt  = saw_rise_r;
    acc_nxt       = acc_r;
    inc_nxt       = inc_r;
    m_nxt         = m_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    sample_nxt    = sample_r;
    mul_a         = {1'b0, mag_r};
    mul_b         = inv_rate_r[MUL_B_W-1:0];

    if (cfg_wr_en) begin
      inv_rate_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt       = in_frequency[FREQ_W-1];
          mag_nxt       = in_frequency[FREQ_W-1] ? (FREQ_W'(0) - FREQ_W'(in_frequency))
                                                 : FREQ_W'(in_frequency);
          saw_fall_nxt  = (in_slope_width <= -WIDTH_ONE);
          saw_rise_nxt  = (in_slope_width >= WIDTH_ONE);
          w_nxt         = w_ext[14:0];
          v_nxt         = 15'(16'(FULL_SCALE) - {1'b0, w_ext[14:0]});
          p_nxt         = p_in;
          phase_acc_nxt = p_in;
          prev_off_nxt  = in_phase_offset;
          state_nxt     = S_MLO;
        end
      end
      S_MLO: begin
        state_nxt = S_MHI;
      end
      S_MHI: begin
        // Negative step rounds towards minus infinity on the magnitude
        acc_nxt   = {1'b0, prod[63:32]} + 33'((neg_r && prod[31:0] != '0) ? 1 : 0);
        mul_b     = {24'd0, inv_rate_r[INV_RATE_W-1:MUL_B_W]};
        state_nxt = S_STEP;
      end
      S_STEP: begin
        phase_acc_nxt = phase_acc_r + step;
        state_nxt     = (saw_fall_r || saw_rise_r) ? S_FIN : S_MINC;
      end
      S_MINC: begin
        mul_a     = {1'b0, p_r};
        mul_b     = {17'd0, w_r};
        state_nxt = S_MDEC;
      end
      S_MDEC: begin
        inc_nxt   = prod[46:0];
        mul_a     = 33'h1_0000_0000 - {1'b0, p_r};
        mul_b     = {17'd0, v_r};
        state_nxt = S_MD;
      end
      S_MD: begin
        m_nxt     = (inc_r < prod[46:0]) ? inc_r : prod[46:0];
        mul_a     = {18'd0, w_r};
        mul_b     = {17'd0, v_r};
        state_nxt = S_DSET;
      end
      S_DSET: begin
        // (m + d) / 2d, quotient fits in 17 bits
        rem_nxt   = {1'b0, m_r} + {18'd0, prod[29:0]};
        dvs_nxt   = {1'b0, prod[29:0], 17'd0};
        quo_nxt   = '0;
        cnt_nxt   = 5'd16;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_ge) begin
          rem_nxt = rem_sub;
        end
        quo_nxt = {quo_r[15:0], rem_ge};
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          sample_nxt    = (res[17:15] == 3'b001) ? 16'h7FFF : res[15:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_acc_r <= '0;
      prev_off_r  <= '0;
      inv_rate_r  <= INV_RATE_RESET;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      phase_acc_r <= phase_acc_nxt;
      prev_off_r  <= prev_off_nxt;
      inv_rate_r  <= inv_rate_nxt;
      cnt_r       <= cnt_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    p_r        <= p_nxt;
    w_r        <= w_nxt;
    v_r        <= v_nxt;
    saw_fall_r <= saw_fall_nxt;
    saw_rise_r <= saw_rise_nxt;
    acc_r      <= acc_nxt;
    inc_r      <= inc_nxt;
    m_r        <= m_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    quo_r      <= quo_nxt;
    sample_r   <= sample_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;

endmodule : variable_slope_oscillator
`default_nettype wire

### sv/vso_mul.sv
// Registered unsigned multiplier shared by the oscillator sequencer.
`default_nettype none
module vso_mul #(
  parameter int unsigned A_W = vso_pkg::MUL_A_W,
  parameter int unsigned B_W = vso_pkg::MUL_B_W
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     op_a,
  input  wire logic [B_W-1:0]     op_b,
  output logic      [A_W+B_W-1:0] prod
);

  logic [A_W+B_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
  end

  assign prod = prod_r;

endmodule : vso_mul
`default_nettype wire

### sv/vso_chk.sv
// Port-level checker for the oscillator, bound to the top level.
`default_nettype none
module vso_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [vso_pkg::SAMPLE_W-1:0] out_sample
);

  // Held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result changed or dropped while stalled");

  // Nothing left on the output after reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // An accepted transaction keeps the sequencer busy through the phase step
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken again during step computation");

  // A new result appears only at the end of a busy interval
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule : vso_chk

bind variable_slope_oscillator vso_chk u_vso_chk (.*);
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the variable-slope oscillator: phase, shaping and flow control.
module testbench;
  import vso_pkg::*;

  // Watchdog: cycles with no transaction on either channel before giving up.
  // The longest quiet stretch in a correct run is the deliberate receiver hold
  // plus the time to finish one item, so this leaves a wide margin.
  localparam int unsigned QUIET_LIMIT     = 2000;
  // Long receiver hold-off, started once the sender has moved this many items.
  localparam int unsigned HOLD_CYCLES     = 250;
  localparam int unsigned HOLD_AT_ITEM    = 400;
  localparam int unsigned RANDOM_PHASES   = 5;
  localparam int unsigned ITEMS_PER_PHASE = 365;
  // Quiet cycles at the end; the slowest path is a triangle through the division.
  localparam int unsigned DRAIN_CYCLES    = 40;
  // Sync value that forces the phase to zero.
  localparam logic [SYNC_W-1:0] SYNC_TO_ZERO = 33'h1_0000_0000;

  // Bit-exact tracker of the oscillator: its own phase, last offset and rate,
  // plus the queue of samples still owed by the block.
  class phase_shaper;
    logic [INV_RATE_W-1:0]      inv_rate;
    logic [PHASE_W-1:0]         phase;
    logic [PHASE_W-1:0]         last_offset;
    logic signed [SAMPLE_W-1:0] due_samples[$];
    int unsigned                mismatches;
    int unsigned                matched;

    function new();
      inv_rate    = INV_RATE_RESET;
      phase       = '0;
      last_offset = '0;
      mismatches  = 0;
      matched     = 0;
    endfunction

    function void load_rate(logic [INV_RATE_W-1:0] rate);
      inv_rate = rate;
    endfunction

    function int unsigned outstanding();
      return due_samples.size();
    endfunction

    function void accept_item(logic [FREQ_W-1:0] freq, logic signed [WIDTH_W-1:0] wid,
                              logic [PHASE_W-1:0] ofs, logic [SYNC_W-1:0] syn);
      logic [63:0]        mag;
      logic [63:0]        low_prod;
      logic [63:0]        quot;
      logic [63:0]        up_prod;
      logic [63:0]        down_prod;
      logic [63:0]        span;
      logic [PHASE_W-1:0] advance;
      logic [PHASE_W-1:0] p;
      longint             w_lo;
      longint             level;

      // step = floor(f * rate / 2^32), magnitude first, floor fixed up for negatives
      mag      = freq[FREQ_W-1] ? {32'd0, -freq} : {32'd0, freq};
      low_prod = mag * {32'd0, inv_rate[31:0]};
      quot     = mag * {56'd0, inv_rate[39:32]} + (low_prod >> 32);
      if (freq[FREQ_W-1] && low_prod[31:0] != 32'd0) quot = quot + 64'd1;
      if (quot > 64'(HALF_STEP)) quot = 64'(HALF_STEP);
      advance = freq[FREQ_W-1] ? -quot[31:0] : quot[31:0];

      // sync jump, reset to zero, or offset delta (plain wraparound)
      if (syn != '0 && !syn[SYNC_W-1]) p = syn[PHASE_W-1:0];
      else if (syn == SYNC_TO_ZERO) p = '0;
      else p = phase + (ofs - last_offset);

      if (wid <= -WIDTH_ONE || wid >= WIDTH_ONE) begin
        // full saws: rounded top 16 bits of the phase
        quot  = ({32'd0, p} + 64'h8000) >> 16;
        level = (wid < 0) ? longint'(FULL_SCALE) - longint'(quot)
                          : longint'(quot) - longint'(FULL_SCALE);
      end else begin
        // triangle: 1 - 2*min(p*w, (1-p)(1-w)) / (w(1-w)), rounded half up
        w_lo      = longint'(wid) + WIDTH_ONE;
        up_prod   = {32'd0, p} * 64'(w_lo);
        down_prod = (64'h1_0000_0000 - {32'd0, p}) * (64'(FULL_SCALE) - 64'(w_lo));
        span      = 64'(w_lo) * (64'(FULL_SCALE) - 64'(w_lo));
        quot      = ((up_prod < down_prod ? up_prod : down_prod) + span) / (2 * span);
        level     = longint'(FULL_SCALE) - longint'(quot);
      end
      // only +1 can overflow Q1.15
      if (level > longint'(FULL_SCALE) - 1) level = longint'(FULL_SCALE) - 1;
      due_samples.push_back(level[SAMPLE_W-1:0]);

      phase       = p + advance;
      last_offset = ofs;
    endfunction

    function void compare_sample(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (due_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("sample %0d arrived with nothing outstanding", got);
        return;
      end
      want = due_samples.pop_front();
      if (got === want) begin
        matched++;
      end else begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample %0d: expected %0d, got %0d", matched + mismatches, want, got);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [INV_RATE_W-1:0]      cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [FREQ_W-1:0]   in_frequency;
  logic signed [WIDTH_W-1:0]  in_slope_width;
  logic [PHASE_W-1:0]         in_phase_offset;
  logic [SYNC_W-1:0]          in_sync;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample;

  bit                         gaps_on;       // random idling on both sides
  int unsigned                items_taken;   // input transactions seen by the monitor
  int unsigned                items_sent;    // input transactions completed by the sender
  int unsigned                samples_seen;  // output transactions seen by the monitor
  int unsigned                quiet_cycles;
  phase_shaper                shaper;

  variable_slope_oscillator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frequency    (in_frequency),
    .in_slope_width  (in_slope_width),
    .in_phase_offset (in_phase_offset),
    .in_sync         (in_sync),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample)
  );

  // 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Monitor: both channels sampled on the rising edge, before any of this
  // edge's updates land. An input transaction books the expected sample; an
  // output transaction is checked against the oldest booking.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        shaper.accept_item(in_frequency, in_slope_width, in_phase_offset, in_sync);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        shaper.compare_sample(out_sample);
        samples_seen++;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transaction for %0d cycles, run abandoned", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: ready by default, random back-pressure bursts while gaps are
  // enabled, and one long hold-off so that the output register fills, the
  // sequencer stalls in its last state and in_ready drops while the sender
  // keeps offering.
  initial begin : sink
    int unsigned hold_left;
    bit          pressed;
    hold_left = 0;
    pressed   = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!pressed && items_taken >= HOLD_AT_ITEM) begin
        pressed   = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Valid is left high
  // on return; the caller either offers the next item straight away or drops
  // valid for a gap.
  task automatic send_item(input logic signed [FREQ_W-1:0] freq,
                           input logic signed [WIDTH_W-1:0] wid,
                           input logic [PHASE_W-1:0] ofs,
                           input logic [SYNC_W-1:0] syn);
    in_valid        <= 1'b1;
    in_frequency    <= freq;
    in_slope_width  <= wid;
    in_phase_offset <= ofs;
    in_sync         <= syn;
    do begin
      @(posedge clk);
    end while (!in_ready);
    items_sent++;
  endtask

  // Let every outstanding sample come back, then write inverse_rate while the
  // block is idle. Every item yields a sample, so an empty pipe means idle.
  task automatic drain_and_set_rate(input logic [INV_RATE_W-1:0] rate);
    in_valid <= 1'b0;
    while (samples_seen < items_sent) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shaper.load_rate(rate);
  endtask

  initial begin : stimulus
    logic [INV_RATE_W-1:0]     rates [RANDOM_PHASES];
    logic [PHASE_W-1:0]        offset_now;
    logic signed [FREQ_W-1:0]  freq;
    logic signed [WIDTH_W-1:0] wid;
    logic [SYNC_W-1:0]         syn;

    shaper          = new();
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_frequency    = '0;
    in_slope_width  = '0;
    in_phase_offset = '0;
    in_sync         = '0;
    gaps_on         = 1'b0;
    offset_now      = '0;

    // Rate settings: both extremes, the 48 kHz default, and two random ones
    // (one restricted to the audio-rate range).
    rates[0]        = '0;
    rates[1]        = '1;
    rates[2][31:0]  = $urandom;
    rates[2][39:32] = 8'($urandom_range(0, 255));
    rates[3]        = INV_RATE_RESET;
    rates[4][31:0]  = $urandom;
    rates[4][39:32] = 8'($urandom_range(0, 3));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, default rate from reset ----
    // phase zero: triangle peak lands exactly on +1 and saturates
    send_item(32'sd0, 16'sd0, 32'h0, 33'h0);
    // falling saw after a sync to zero also hits +1
    send_item(32'sd0, -16'sd16384, 32'h0, SYNC_TO_ZERO);
    // rising saw just short of the wrap rounds up to +1
    send_item(32'sd0, 16'sd16384, 32'h0, 33'h0_FFFF_8000);
    // widths beyond +/-1 are clipped to the saws
    send_item(32'sd0, 16'sh8000, 32'h0, 33'h1);
    send_item(32'sd0, 16'sh7FFF, 32'h0, 33'h0_FFFF_FFFF);
    // narrowest triangles, peak hard against either end
    send_item(32'sd0, -16'sd16383, 32'h0, 33'h0_8000_0000);
    send_item(32'sd0, 16'sd16383, 32'h0, 33'h0_4000_0000);
    // extreme frequencies: the step clips at one half in both directions,
    // and sync values above 2^32 are ignored
    send_item(32'sh7FFF_FFFF, -16'sd1, 32'hFFFF_FFFF, 33'h1_0000_0001);
    send_item(32'sh8000_0000, 16'sd0, 32'h0, 33'h1_FFFF_FFFF);
    // tiny frequencies either side of zero; offset steps forward, then holds
    send_item(-32'sd1, 16'sd1, 32'h1234_5678, 33'h0);
    send_item(32'sd1, -16'sd16385, 32'h1234_5678, 33'h0);
    // 440 Hz both ways, offset jumping by a half
    send_item(32'sd28835840, 16'sd0, 32'h0, 33'h0);
    send_item(-32'sd28835840, 16'sd8192, 32'h8000_0000, 33'h0);
    // 1 Hz with a sync to zero, then 20 kHz on a rising saw
    send_item(32'sd65536, -16'sd8192, 32'h8000_0000, SYNC_TO_ZERO);
    send_item(32'sd1310720000, 16'sd16384, 32'hFFFF_FFFF, 33'h0);
    send_item(32'sd0, -16'sd16384, 32'h0, 33'h0_0000_7FFF);
    send_item(32'sd0, 16'sd4096, 32'h0, 33'h0_FFFF_FFFF);
    send_item(32'sh7FFF_FFFF, 16'sh7FFF, 32'h7FFF_FFFF, SYNC_TO_ZERO);

    // ---- random part, one phase per rate setting ----
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_and_set_rate(rates[ph]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // alternate windows with and without idling; none in the last phase
        gaps_on = (ph != RANDOM_PHASES - 1) && ((k / 100) % 2 == 0);

        // mostly audio-range frequencies, some full-range and extremes
        case ($urandom_range(0, 7))
          0: freq = $urandom;
          1: freq = ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          default: begin
            freq = $urandom_range(0, 1310720000);
            if ($urandom_range(0, 1) == 1) freq = -freq;
          end
        endcase

        // mostly triangles, with saws, near-saws and out-of-range widths
        case ($urandom_range(0, 5))
          0: wid = WIDTH_W'($urandom);
          1: wid = ($urandom_range(0, 1) == 1) ? WIDTH_W'(WIDTH_ONE) : WIDTH_W'(-WIDTH_ONE);
          2: wid = ($urandom_range(0, 1) == 1) ? WIDTH_W'(WIDTH_ONE - 1)
                                               : WIDTH_W'(1 - WIDTH_ONE);
          default: wid = WIDTH_W'($urandom_range(0, 2 * WIDTH_ONE - 2) - (WIDTH_ONE - 1));
        endcase

        // offset mostly steady, sometimes nudged, sometimes jumped anywhere
        case ($urandom_range(0, 9))
          0, 1: offset_now = $urandom;
          2, 3, 4: offset_now = offset_now + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
          default: ;
        endcase

        // sync mostly idle; otherwise a jump, a reset or an ignored value
        case ($urandom_range(0, 15))
          0, 1: syn = {1'b0, $urandom};
          2: syn = SYNC_TO_ZERO;
          3: syn = {1'b1, $urandom};
          default: syn = '0;
        endcase

        if (gaps_on && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        send_item(freq, wid, offset_now, syn);
      end
    end

    // ---- wind down ----
    gaps_on = 1'b0;
    in_valid <= 1'b0;
    while (samples_seen < items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items over %0d rate settings: saws, triangles, clipped widths and steps,",
             items_sent, RANDOM_PHASES + 1);
    $display("every sync mode, random stalls and one long output hold; %0d samples matched",
             shaper.matched);
    if (shaper.mismatches == 0 && shaper.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
